// File: hw/rtl/ordered_array_list_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array list
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_TOP_ASSERT_SVH
`define ORDERED_ARRAY_LIST_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every edge out of reset
`define OAL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ordered array list check failed");
// condition must never be true out of reset
`define OAL_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("ordered array list forbidden condition");
`else
`define OAL_ASSERT(lbl, clk, rstn, prop)
`define OAL_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hw/rtl/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and constants of the ordered array list.
// ----------------------------------------------------------------------------
package oal_pkg;

    localparam int OAL_CAPACITY = 64;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_LOCATE = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } oal_op_t;

    typedef struct packed {
        oal_op_t     op;
        logic [6:0]  position;
        logic [7:0]  element;
    } oal_in_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  data_out;
        logic [6:0]  found_position;
        logic [6:0]  count;
        logic        is_empty;
    } oal_out_t;

endpackage

// File: hw/rtl/oal_ram.sv
// ----------------------------------------------------------------------------
// oal_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ordered_array_list_top.sv
// ----------------------------------------------------------------------------
// ordered_array_list_top
// Bounded ordered byte list with read, locate, insert and delete requests.
// ----------------------------------------------------------------------------
// The list lives in one RAM with a registered read, and every request walks it
// one entry per cycle. A locate stops early when the key is found, and an insert
// or delete moves the shifted tail one element per cycle through the read and
// write ports of the RAM. One request is in work at a time; a finished result
// sits in an output register so the next item can be taken while it waits.
// Positions are 1-based; a bad position or an insert into a full list leaves
// the list untouched and returns ok=0.
// ----------------------------------------------------------------------------
`include "ordered_array_list_top_assert.svh"

module ordered_array_list_top
    import oal_pkg::*;
#(
    parameter int CAPACITY = OAL_CAPACITY
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  oal_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output oal_out_t m_data
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = ((LEN_W > 7) ? LEN_W : 7) + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    oal_op_t           op_reg, op_next;
    logic [AW-1:0]     pos_addr_reg, pos_addr_next;
    logic [7:0]        elem_reg, elem_next;
    logic              ok_reg, ok_next;
    logic [7:0]        data_reg, data_next;
    logic [6:0]        found_reg, found_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0]  rd_left_reg, rd_left_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              m_valid_reg, m_valid_next;
    oal_out_t          m_data_reg, m_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [7:0]        ram_rdata;

    logic [CW-1:0]     pos_x, len_x;
    logic              pos_in_list, ins_ok, accept, out_free;
    logic [LEN_W-1:0]  len_new;

    oal_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign pos_x       = CW'(s_data.position);
    assign len_x       = CW'(len_reg);
    assign pos_in_list = (pos_x != '0) && (pos_x <= len_x);
    assign ins_ok      = (pos_x != '0) && (pos_x <= len_x + CW'(1))
                         && (len_x < CW'(CAPACITY));

    assign ram_re = (state_reg == ST_RUN) && (rd_left_reg != '0);

    // Write port: tail shift while walking, the new element once at the end.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        if (state_reg == ST_RUN && pend_reg) begin
            if (op_reg == OP_INSERT) begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr_reg + AW'(1);
            end else if (op_reg == OP_DELETE && pend_addr_reg != pos_addr_reg) begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr_reg - AW'(1);
            end
        end else if (state_reg == ST_FIN && out_free && op_reg == OP_INSERT && ok_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pos_addr_reg;
            ram_wdata = elem_reg;
        end
    end

    always_comb begin
        len_new = len_reg;
        if (ok_reg && op_reg == OP_INSERT) begin
            len_new = len_reg + LEN_W'(1);
        end else if (ok_reg && op_reg == OP_DELETE) begin
            len_new = len_reg - LEN_W'(1);
        end
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        op_next        = op_reg;
        pos_addr_next  = pos_addr_reg;
        elem_next      = elem_reg;
        ok_next        = ok_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        rd_addr_next   = rd_addr_reg;
        rd_left_next   = rd_left_reg;
        pend_next      = 1'b0;
        pend_addr_next = rd_addr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next       = s_data.op;
                    pos_addr_next = AW'(pos_x - CW'(1));
                    elem_next     = s_data.element;
                    data_next     = '0;
                    found_next    = '0;
                    hit_next      = 1'b0;
                    rd_addr_next  = AW'(pos_x - CW'(1));
                    state_next    = ST_RUN;
                    case (s_data.op)
                        OP_READ: begin
                            ok_next      = pos_in_list;
                            rd_left_next = pos_in_list ? LEN_W'(1) : '0;
                        end
                        OP_LOCATE: begin
                            ok_next      = 1'b1;
                            rd_addr_next = '0;
                            rd_left_next = len_reg;
                        end
                        OP_INSERT: begin
                            // shift walks down from the last element
                            ok_next      = ins_ok;
                            rd_addr_next = AW'(len_x - CW'(1));
                            rd_left_next = ins_ok ? LEN_W'(len_x - pos_x + CW'(1)) : '0;
                        end
                        OP_DELETE: begin
                            ok_next      = pos_in_list;
                            rd_left_next = pos_in_list ? LEN_W'(len_x - pos_x + CW'(1)) : '0;
                        end
                        default: begin
                            ok_next      = 1'b0;
                            rd_left_next = '0;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (ram_re) begin
                    pend_next    = 1'b1;
                    rd_left_next = rd_left_reg - LEN_W'(1);
                    rd_addr_next = (op_reg == OP_INSERT) ? rd_addr_reg - AW'(1)
                                                         : rd_addr_reg + AW'(1);
                end
                if (pend_reg) begin
                    if (op_reg == OP_READ) begin
                        data_next = ram_rdata;
                    end else if (op_reg == OP_DELETE && pend_addr_reg == pos_addr_reg) begin
                        data_next = ram_rdata;
                    end else if (op_reg == OP_LOCATE && !hit_reg && ram_rdata == elem_reg) begin
                        // first match ends the scan; a read already in flight is ignored
                        hit_next     = 1'b1;
                        found_next   = 7'({1'b0, pend_addr_reg} + (AW + 1)'(1));
                        rd_left_next = '0;
                        pend_next    = 1'b0;
                    end
                end
                if (rd_left_reg == '0 && !pend_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    len_next                   = len_new;
                    m_valid_next               = 1'b1;
                    m_data_next.ok             = ok_reg;
                    m_data_next.data_out       = data_reg;
                    m_data_next.found_position = found_reg;
                    m_data_next.count          = 7'(len_new);
                    m_data_next.is_empty       = (len_new == '0);
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            rd_left_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            rd_left_reg <= rd_left_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        pos_addr_reg  <= pos_addr_next;
        elem_reg      <= elem_next;
        ok_reg        <= ok_next;
        data_reg      <= data_next;
        found_reg     <= found_next;
        hit_reg       <= hit_next;
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        m_data_reg    <= m_data_next;
    end

    `OAL_ASSERT(a_len_bound, aclk, aresetn, (CW'(len_reg) <= CW'(CAPACITY)))
    `OAL_NEVER(a_no_idle_write, aclk, aresetn, (state_reg == ST_IDLE) && ram_we)
    `OAL_NEVER(a_rw_overlap, aclk, aresetn, ram_we && ram_re && (ram_waddr == rd_addr_reg))
    `OAL_ASSERT(a_result_from_fin, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))

endmodule
